// ===== design/otc_pkg.sv =====
// ----------------------------------------------------------------------------
// otc_pkg
// shared types, codes, constants and helper functions of the oven timer
// ----------------------------------------------------------------------------
package otc_pkg;

  localparam logic [1:0] ST_SETUP  = 2'd0;
  localparam logic [1:0] ST_SELECT = 2'd1;
  localparam logic [1:0] ST_COOK   = 2'd2;
  localparam logic [1:0] ST_RESET  = 2'd3;

  localparam logic [1:0] MODE_BAKE  = 2'd0;
  localparam logic [1:0] MODE_TOAST = 2'd1;
  localparam logic [1:0] MODE_BROIL = 2'd2;

  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_BUTTON = 2'd1;
  localparam logic [1:0] KIND_ADC    = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam logic [1:0] REG_HOLD_LIMIT = 2'd0;
  localparam logic [1:0] REG_TICKS_SEC  = 2'd1;
  localparam logic [1:0] REG_ADC_FLOOR  = 2'd2;
  localparam logic [1:0] REG_ADC_HYST   = 2'd3;

  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;

  localparam logic [7:0] RST_HOLD_LIMIT = 8'd5;
  localparam logic [7:0] RST_TICKS_SEC  = 8'd5;
  localparam logic [9:0] RST_ADC_FLOOR  = 10'd5;
  localparam logic [9:0] RST_ADC_HYST   = 10'd3;

  localparam logic [9:0] TEMP_BASE    = 10'd300;
  localparam logic [9:0] TEMP_DEFAULT = 10'd350;
  localparam logic [9:0] TEMP_BROIL   = 10'd500;
  localparam logic [5:0] SEC_MAX      = 6'd59;
  localparam logic [5:0] SEC_DEFAULT  = 6'd1;
  localparam logic [7:0] LED_FULL     = 8'hFF;
  localparam logic [4:0] LED_STEP_MAX = 5'd31;
  localparam logic [8:0] SEC_PER_MIN  = 9'd60;
  localparam logic [9:0] ADC_DIV      = 10'd1023;

  typedef struct packed {
    logic [7:0] hold_limit;
    logic [7:0] ticks_sec;
    logic [9:0] adc_floor;
    logic [9:0] adc_hyst;
  } cfg_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       btn3_down;
    logic       btn3_up;
    logic       btn4_down;
    logic       btn4_up;
    logic [9:0] adc_value;
    logic [7:0] adc_scaled;
  } item_t;

  typedef struct packed {
    logic       bottom_heater;
    logic       top_heater;
    logic [7:0] led_bar;
    logic [9:0] temperature;
    logic [5:0] seconds;
    logic [2:0] minutes;
    logic       temp_selected;
    logic [1:0] oven_mode;
    logic [1:0] oven_state;
  } res_t;

  // floor(v * 255 / 1023): quotient by 1024 is low by at most one
  function automatic logic [7:0] scale_adc(input logic [9:0] v);
    logic [17:0] x;
    logic [7:0]  q0;
    logic [17:0] r;
    x  = {v, 8'b0} - {8'b0, v};
    q0 = x[17:10];
    r  = x - {q0, 10'b0} + {10'b0, q0};
    if (r >= {8'b0, ADC_DIV}) begin
      return q0 + 8'd1;
    end
    return q0;
  endfunction

  // split a count of seconds (up to 255) into minutes and seconds
  function automatic logic [8:0] split_time(input logic [7:0] c);
    logic [2:0] m;
    logic [7:0] s;
    if (c >= 8'd240) begin
      m = 3'd4;
      s = c - 8'd240;
    end else if (c >= 8'd180) begin
      m = 3'd3;
      s = c - 8'd180;
    end else if (c >= 8'd120) begin
      m = 3'd2;
      s = c - 8'd120;
    end else if (c >= 8'd60) begin
      m = 3'd1;
      s = c - 8'd60;
    end else begin
      m = 3'd0;
      s = c;
    end
    return {m, s[5:0]};
  endfunction

endpackage

// ===== design/otc_adc_scale.sv =====
// ----------------------------------------------------------------------------
// otc_adc_scale
// scales a raw 10-bit reading to the 0..255 setting range
// ----------------------------------------------------------------------------
module otc_adc_scale (
  input  logic [9:0] adc_value_i,
  output logic [7:0] adc_scaled_o
);
  import otc_pkg::*;

  assign adc_scaled_o = scale_adc(adc_value_i);

endmodule

// ===== design/otc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// otc_cfg_regs
// configuration register file behind the apb port
// ----------------------------------------------------------------------------
module otc_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [otc_pkg::APB_AW-1:0]  paddr,
  input  logic [otc_pkg::APB_DW-1:0]  pwdata,
  output logic [otc_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output otc_pkg::cfg_t               cfg_o
);
  import otc_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic [1:0] idx;
  logic       wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_HOLD_LIMIT: cfg_d.hold_limit = pwdata[7:0];
        REG_TICKS_SEC:  cfg_d.ticks_sec  = pwdata[7:0];
        REG_ADC_FLOOR:  cfg_d.adc_floor  = pwdata[9:0];
        REG_ADC_HYST:   cfg_d.adc_hyst   = pwdata[9:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_HOLD_LIMIT: prdata = {24'b0, cfg_q.hold_limit};
      REG_TICKS_SEC:  prdata = {24'b0, cfg_q.ticks_sec};
      REG_ADC_FLOOR:  prdata = {22'b0, cfg_q.adc_floor};
      REG_ADC_HYST:   prdata = {22'b0, cfg_q.adc_hyst};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hold_limit <= RST_HOLD_LIMIT;
      cfg_q.ticks_sec  <= RST_TICKS_SEC;
      cfg_q.adc_floor  <= RST_ADC_FLOOR;
      cfg_q.adc_hyst   <= RST_ADC_HYST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/otc_core.sv =====
// ----------------------------------------------------------------------------
// otc_core
// oven controller state and its update for one request
// ----------------------------------------------------------------------------
module otc_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  otc_pkg::cfg_t  cfg_i,
  input  logic           item_valid_i,
  input  otc_pkg::item_t item_i,
  output otc_pkg::res_t  res_o
);
  import otc_pkg::*;

  logic [1:0]  st_q, st_d;
  logic [1:0]  mode_q, mode_d;
  logic        sel_q, sel_d;
  logic [2:0]  min_q, min_d;
  logic [5:0]  sec_q, sec_d;
  logic [9:0]  temp_q, temp_d;
  logic [7:0]  led_q, led_d;
  logic [4:0]  len_q, len_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] tick_q, tick_d;
  logic [31:0] mark_q, mark_d;
  logic [7:0]  div_q, div_d;
  logic [9:0]  adc_q, adc_d;
  logic [7:0]  adc_c_q, adc_c_d;
  logic        seen_q, seen_d;

  logic [31:0] held;
  logic        is_long;
  logic [7:0]  div_inc;
  logic [8:0]  total;
  logic [5:0]  len_raw;
  logic [4:0]  len_sat;
  logic [4:0]  cnt_inc;
  logic [9:0]  diff;
  logic        step;
  logic        hot;
  logic [8:0]  ms;

  always_comb begin
    st_d    = st_q;
    mode_d  = mode_q;
    sel_d   = sel_q;
    min_d   = min_q;
    sec_d   = sec_q;
    temp_d  = temp_q;
    led_d   = led_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    tick_d  = tick_q;
    mark_d  = mark_q;
    div_d   = div_q;
    adc_d   = adc_q;
    adc_c_d = adc_c_q;
    seen_d  = seen_q;
    step    = 1'b0;
    ms      = '0;

    held    = tick_q - mark_q;
    is_long = held >= {24'b0, cfg_i.hold_limit};
    div_inc = div_q + 8'd1;
    total   = {6'b0, min_q} * SEC_PER_MIN + {3'b0, sec_q};
    len_raw = total[8:3];
    len_sat = (len_raw > {1'b0, LED_STEP_MAX}) ? LED_STEP_MAX : len_raw[4:0];
    cnt_inc = cnt_q + 5'd1;
    diff    = (item_i.adc_value > adc_q) ? item_i.adc_value - adc_q
                                         : adc_q - item_i.adc_value;

    if (item_valid_i) begin
      unique case (item_i.kind)
        KIND_TICK: begin
          tick_d = tick_q + 32'd1;
          div_d  = div_inc;
          if (div_inc >= cfg_i.ticks_sec) begin
            div_d = '0;
            if (st_q == ST_COOK) begin
              if (sec_q == '0) begin
                if (min_q == '0) begin
                  st_d   = ST_SETUP;
                  mode_d = MODE_BAKE;
                  sel_d  = 1'b0;
                  min_d  = '0;
                  sec_d  = SEC_DEFAULT;
                  temp_d = TEMP_DEFAULT;
                  led_d  = '0;
                end else begin
                  min_d = min_q - 3'd1;
                  sec_d = SEC_MAX;
                  step  = 1'b1;
                end
              end else begin
                sec_d = sec_q - 6'd1;
                step  = 1'b1;
              end
            end
          end
        end
        KIND_BUTTON: begin
          unique case (st_q)
            ST_SETUP: begin
              priority if (item_i.btn3_down) begin
                mark_d = tick_q;
                st_d   = ST_SELECT;
              end else if (item_i.btn4_down) begin
                mark_d = tick_q;
                led_d  = LED_FULL;
                len_d  = len_sat;
                cnt_d  = '0;
                st_d   = ST_COOK;
              end else begin
              end
            end
            ST_SELECT: begin
              if (item_i.btn3_up) begin
                if (!is_long) begin
                  sel_d = 1'b0;
                  unique case (mode_q)
                    MODE_BAKE:  mode_d = MODE_TOAST;
                    MODE_TOAST: begin
                      mode_d = MODE_BROIL;
                      temp_d = TEMP_BROIL;
                    end
                    default: begin
                      mode_d = MODE_BAKE;
                      temp_d = TEMP_DEFAULT;
                    end
                  endcase
                end else if (mode_q == MODE_BAKE) begin
                  sel_d = !sel_q;
                end
                st_d = ST_SETUP;
              end
            end
            ST_COOK: begin
              if (item_i.btn4_down) begin
                mark_d = tick_q;
                st_d   = ST_RESET;
              end
            end
            ST_RESET: begin
              if (item_i.btn4_up) begin
                if (!is_long) begin
                  st_d = ST_COOK;
                end else begin
                  st_d   = ST_SETUP;
                  mode_d = MODE_BAKE;
                  sel_d  = 1'b0;
                  min_d  = '0;
                  sec_d  = SEC_DEFAULT;
                  temp_d = TEMP_DEFAULT;
                  led_d  = '0;
                end
              end
            end
          endcase
        end
        KIND_ADC: begin
          if (item_i.adc_value > cfg_i.adc_floor && diff > cfg_i.adc_hyst) begin
            adc_d   = item_i.adc_value;
            adc_c_d = item_i.adc_scaled;
            seen_d  = 1'b1;
          end
        end
        KIND_UNUSED: begin
        end
      endcase

      if (step) begin
        cnt_d = cnt_inc;
        if (len_q != '0 && cnt_inc == len_q) begin
          led_d = {led_q[6:0], 1'b0};
          cnt_d = '0;
        end
      end

      if (seen_d && st_d == ST_SETUP) begin
        ms = split_time(adc_c_d);
        if (!sel_d) begin
          min_d = ms[8:6];
          sec_d = ms[5:0];
        end else begin
          temp_d = TEMP_BASE + {2'b0, adc_c_d};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_SETUP;
      mode_q  <= MODE_BAKE;
      sel_q   <= 1'b0;
      min_q   <= '0;
      sec_q   <= SEC_DEFAULT;
      temp_q  <= TEMP_DEFAULT;
      led_q   <= '0;
      len_q   <= '0;
      cnt_q   <= '0;
      tick_q  <= '0;
      mark_q  <= '0;
      div_q   <= '0;
      adc_q   <= '0;
      adc_c_q <= '0;
      seen_q  <= 1'b0;
    end else begin
      st_q    <= st_d;
      mode_q  <= mode_d;
      sel_q   <= sel_d;
      min_q   <= min_d;
      sec_q   <= sec_d;
      temp_q  <= temp_d;
      led_q   <= led_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      tick_q  <= tick_d;
      mark_q  <= mark_d;
      div_q   <= div_d;
      adc_q   <= adc_d;
      adc_c_q <= adc_c_d;
      seen_q  <= seen_d;
    end
  end

  assign hot = (st_d == ST_COOK) || (st_d == ST_RESET);

  always_comb begin
    res_o.oven_state    = st_d;
    res_o.oven_mode     = mode_d;
    res_o.temp_selected = sel_d;
    res_o.minutes       = min_d;
    res_o.seconds       = sec_d;
    res_o.temperature   = temp_d;
    res_o.led_bar       = led_d;
    res_o.top_heater    = hot && (mode_d == MODE_BAKE || mode_d == MODE_BROIL);
    res_o.bottom_heater = hot && (mode_d == MODE_BAKE || mode_d == MODE_TOAST);
  end

endmodule

// ===== design/oven_timer_controller.sv =====
// ----------------------------------------------------------------------------
// oven_timer_controller
// oven controller driven by tick, button and adc requests over a stream port
// ----------------------------------------------------------------------------
// Every request on the input stream returns exactly one result on the output
// stream, holding the oven settings and heater outputs after that request.
// A request passes through the input register (the adc reading is scaled on
// its way in) and then through the controller update into the output
// register. One request is taken every cycle while the output side keeps
// up; a stalled result blocks input only once both registers are full. The
// user must write registers over apb only while the block is idle; the
// block itself does not enforce this.
// ----------------------------------------------------------------------------
module oven_timer_controller (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [otc_pkg::APB_AW-1:0]  paddr,
  input  logic [otc_pkg::APB_DW-1:0]  pwdata,
  output logic [otc_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // btn3_down, btn3_up, btn4_down, btn4_up, adc_value[9:0], zero pad
  input  logic [15:0]                 s_axis_tdata,
  // kind[1:0]
  input  logic [1:0]                  s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // oven_state[1:0], oven_mode[1:0], temp_selected, minutes[2:0],
  // seconds[5:0], temperature[9:0], led_bar[7:0], top_heater,
  // bottom_heater, zero pad
  output logic [39:0]                 m_axis_tdata
);
  import otc_pkg::*;

  cfg_t       cfg;
  item_t      in_q, in_d;
  logic       in_valid_q;
  logic       out_valid_q;
  res_t       res;
  res_t       out_q;
  logic       step_en;
  logic       in_take;
  logic [7:0] scaled;

  otc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  otc_adc_scale u_scale (
    .adc_value_i  (s_axis_tdata[13:4]),
    .adc_scaled_o (scaled)
  );

  assign step_en       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step_en;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_d.kind       = s_axis_tuser;
    in_d.btn3_down  = s_axis_tdata[0];
    in_d.btn3_up    = s_axis_tdata[1];
    in_d.btn4_down  = s_axis_tdata[2];
    in_d.btn4_up    = s_axis_tdata[3];
    in_d.adc_value  = s_axis_tdata[13:4];
    in_d.adc_scaled = scaled;
  end

  otc_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (step_en),
    .item_i       (in_q),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (step_en) begin
        in_valid_q <= 1'b0;
      end
      if (step_en) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_d;
    end
    if (step_en) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_q.bottom_heater, out_q.top_heater, out_q.led_bar,
                          out_q.temperature, out_q.seconds, out_q.minutes,
                          out_q.temp_selected, out_q.oven_mode, out_q.oven_state};

endmodule
